@@ hdl/v3a_pkg.sv @@
// Package for the three-component fixed-point vector unit.
// Mode codes, widths, pipeline sideband types and the saturation helper.
// No dependencies.
package v3a_pkg;

  typedef enum logic [3:0] {
    MODE_NEG   = 4'd0,
    MODE_ADD_S = 4'd1,
    MODE_ADD   = 4'd2,
    MODE_SUB_S = 4'd3,
    MODE_SUB   = 4'd4,
    MODE_MUL_S = 4'd5,
    MODE_DOT   = 4'd6,
    MODE_CROSS = 4'd7,
    MODE_MAG   = 4'd8,
    MODE_UNIT  = 4'd9,
    MODE_EQ    = 4'd10
  } mode_t;

  localparam int WORD_W   = 32;          // Q-format word
  localparam int SQ_W     = 64;          // squares, sums, radicands
  localparam int ROOT_W   = 33;          // rounded root of a 64-bit value
  localparam int SQRT_LAT = SQ_W / 2 + 1; // one stage per root bit, plus rounding
  localparam int WIDE_W   = 66;          // headroom for sums before saturation
  localparam int KW       = 5;           // normalization shift count (0..30)
  localparam int NORM_TOP = 60;          // normalized radicand is at least 2^60

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [2:0][WORD_W-1:0] vec_t;   // [0] = x, [1] = y, [2] = z

  typedef struct packed {
    logic [SQ_W-1:0] s;
    logic [KW-1:0]   k;
  } norm_t;

  // Per-item data that rides alongside the root and divide pipelines.
  typedef struct packed {
    mode_t         mode;
    vec_t          a;
    vec_t          b;
    vec_t          res;   // result of the short modes
    logic          eq;
    logic          za;    // first vector is zero
    logic          zb;    // second vector is zero
    logic [KW-1:0] ka;
    logic [KW-1:0] kb;
    word_t         mag;   // saturated magnitude of the first vector
  } side_t;

  localparam logic signed [WIDE_W-1:0] SAT_HI = WIDE_W'(64'sh7FFF_FFFF);
  localparam logic signed [WIDE_W-1:0] SAT_LO = -SAT_HI - WIDE_W'(1);

  function automatic word_t sat_word(input logic signed [WIDE_W-1:0] v);
    if (v > SAT_HI) begin
      return 32'h7FFF_FFFF;
    end else if (v < SAT_LO) begin
      return 32'h8000_0000;
    end else begin
      return v[WORD_W-1:0];
    end
  endfunction

endpackage

@@ hdl/v3a_sqrt.sv @@
// Pipelined rounded integer square root, one result bit per stage.
// Depends on v3a_pkg (SQ_W, ROOT_W).
module v3a_sqrt import v3a_pkg::*; (
  input  logic              clk,
  input  logic [SQ_W-1:0]   rad,
  output logic [ROOT_W-1:0] root
);

  localparam int STEPS = SQ_W / 2;

  logic [SQ_W-1:0]   rem_r [STEPS];
  logic [SQ_W-1:0]   acc_r [STEPS];
  logic [ROOT_W-1:0] root_r;

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
    logic [SQ_W-1:0] rem_in;
    logic [SQ_W-1:0] acc_in;
    logic [SQ_W-1:0] trial;

    if (i == 0) begin : g_first
      assign rem_in = rad;
      assign acc_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign acc_in = acc_r[i-1];
    end

    assign trial = acc_in + BIT;

    always_ff @(posedge clk) begin
      if (rem_in >= trial) begin
        rem_r[i] <= rem_in - trial;
        acc_r[i] <= (acc_in >> 1) + BIT;
      end else begin
        rem_r[i] <= rem_in;
        acc_r[i] <= acc_in >> 1;
      end
    end
  end

  // round to nearest: bump when the remainder exceeds the root
  always_ff @(posedge clk) begin
    root_r <= acc_r[STEPS-1][ROOT_W-1:0]
              + ROOT_W'(rem_r[STEPS-1] > acc_r[STEPS-1]);
  end

  assign root = root_r;

endmodule

@@ hdl/v3a_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on v3a_pkg (SQ_W, ROOT_W); needs num < den * 2^QB.
module v3a_div import v3a_pkg::*; #(
  parameter int QB = 18
) (
  input  logic              clk,
  input  logic [SQ_W-1:0]   num,
  input  logic [ROOT_W-1:0] den,
  output logic [QB-1:0]     quo
);

  logic [SQ_W-1:0]   rem_r [QB];
  logic [ROOT_W-1:0] den_r [QB];
  logic [QB-1:0]     quo_r [QB];

  for (genvar i = 0; i < QB; i++) begin : g_step
    logic [SQ_W-1:0]   rem_in;
    logic [ROOT_W-1:0] den_in;
    logic [QB-1:0]     quo_in;
    logic [SQ_W-1:0]   dsh;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign dsh = SQ_W'(den_in) << (QB - 1 - i);

    always_ff @(posedge clk) begin
      den_r[i] <= den_in;
      if (rem_in >= dsh) begin
        rem_r[i] <= rem_in - dsh;
        quo_r[i] <= quo_in | (QB'(1) << (QB - 1 - i));
      end else begin
        rem_r[i] <= rem_in;
        quo_r[i] <= quo_in;
      end
    end
  end

  assign quo = quo_r[QB-1];

endmodule

@@ hdl/vector3_fixed_point_alu.sv @@
// Top level of the three-component fixed-point vector unit.
// Depends on v3a_pkg, v3a_sqrt and v3a_div.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+---------------------------------
//  input   | in_mode, in_first_*, in_second_*,       | word taken when start && !busy
//          | in_scalar_in                            |
//  result  | out_x/y/z, out_scalar, out_equal_flag,  | out_valid high for one cycle,
//          | out_error_flag                          | taken at the end of that cycle
//
// One word enters per cycle, every cycle; busy never rises.
// Every mode takes the same path: four front stages (products, sums, two normalize
// stages), the 33-stage root, a numerator stage, the FRACTION_BITS+2-stage divider
// (FRACTION_BITS is 16 for Q16.16), a product stage and the output register.
// Reset (synchronous, active low) clears only the valid line and the strobe; words in
// flight are dropped. The receiver cannot stall, so nothing in the pipe ever holds.
module vector3_fixed_point_alu import v3a_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_mode,
  input  logic [31:0] in_first_x,
  input  logic [31:0] in_first_y,
  input  logic [31:0] in_first_z,
  input  logic [31:0] in_second_x,
  input  logic [31:0] in_second_y,
  input  logic [31:0] in_second_z,
  input  logic [31:0] in_scalar_in,
  output logic        out_valid,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [31:0] out_scalar,
  output logic        out_equal_flag,
  output logic        out_error_flag
);

  // quotient of a unit component is at most 2^F + 1
  localparam int QB      = FRACTION_BITS + 2;
  localparam int UW      = QB + 1;             // signed unit component
  localparam int PW      = 2 * UW;             // unit x unit product
  localparam int NUM_J   = SQRT_LAT + 1;       // sideband index of the numerator stage
  localparam int DIVQ_J  = NUM_J + QB;         // quotients ready
  localparam int PROD_J  = DIVQ_J + 1;         // dot products ready
  localparam int SIDE_N  = PROD_J + 1;
  localparam int VL      = 3 + SIDE_N;         // valid line length
  localparam int LAT     = VL + 1;             // accept edge to strobe sample
  localparam logic signed [WIDE_W-1:0] HALF_W = WIDE_W'(1) << (FRACTION_BITS - 1);

  // fixed-depth pipeline, always ready
  assign busy = 1'b0;

  function automatic norm_t norm_step(input norm_t v, input int sh, input int thr);
    norm_t o;
    o = v;
    if ((v.s >> thr) == '0) begin
      o.s = v.s << (2 * sh);
      o.k = v.k + KW'(sh);
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // valid line: bit n marks stage n+1
  // ---------------------------------------------------------------------------
  logic [VL-1:0] vld_r;
  logic          out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[VL-2:0], start && !busy};
      out_valid_r <= vld_r[VL-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: all products straight off the ports
  // ---------------------------------------------------------------------------
  vec_t in_a;
  vec_t in_b;
  assign in_a = {in_first_z, in_first_y, in_first_x};
  assign in_b = {in_second_z, in_second_y, in_second_x};

  mode_t                  s1_mode_r;
  vec_t                   s1_a_r;
  vec_t                   s1_b_r;
  word_t                  s1_s_r;
  logic [SQ_W-1:0]        s1_sqa_r [3];
  logic [SQ_W-1:0]        s1_sqb_r [3];
  logic signed [SQ_W-1:0] s1_pm_r  [3];   // a * scalar
  logic signed [SQ_W-1:0] s1_pcp_r [3];   // cross, positive term
  logic signed [SQ_W-1:0] s1_pcn_r [3];   // cross, negative term

  always_ff @(posedge clk) begin
    s1_mode_r <= mode_t'(in_mode);
    s1_a_r    <= in_a;
    s1_b_r    <= in_b;
    s1_s_r    <= in_scalar_in;
  end

  for (genvar i = 0; i < 3; i++) begin : g_s1
    localparam int I1 = (i + 1) % 3;
    localparam int I2 = (i + 2) % 3;
    word_t abs_a;
    word_t abs_b;
    assign abs_a = in_a[i][WORD_W-1] ? -in_a[i] : in_a[i];
    assign abs_b = in_b[i][WORD_W-1] ? -in_b[i] : in_b[i];

    always_ff @(posedge clk) begin
      s1_sqa_r[i] <= SQ_W'(abs_a) * SQ_W'(abs_a);
      s1_sqb_r[i] <= SQ_W'(abs_b) * SQ_W'(abs_b);
      s1_pm_r[i]  <= SQ_W'($signed(in_a[i])) * SQ_W'($signed(in_scalar_in));
      s1_pcp_r[i] <= SQ_W'($signed(in_a[I1])) * SQ_W'($signed(in_b[I2]));
      s1_pcn_r[i] <= SQ_W'($signed(in_a[I2])) * SQ_W'($signed(in_b[I1]));
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: short modes finish here; sums of squares
  // ---------------------------------------------------------------------------
  side_t           s2_side_nxt;
  side_t           s2_side_r;
  logic [SQ_W-1:0] s2_sa_r;
  logic [SQ_W-1:0] s2_sb_r;
  vec_t            s2_res;

  for (genvar i = 0; i < 3; i++) begin : g_s2
    logic signed [WIDE_W-1:0] aw;
    logic signed [WIDE_W-1:0] bw;
    logic signed [WIDE_W-1:0] sw;
    logic signed [WIDE_W-1:0] v;

    assign aw = WIDE_W'($signed(s1_a_r[i]));
    assign bw = WIDE_W'($signed(s1_b_r[i]));
    assign sw = WIDE_W'($signed(s1_s_r));

    always_comb begin
      case (s1_mode_r)
        MODE_NEG:   v = -aw;
        MODE_ADD_S: v = aw + sw;
        MODE_ADD:   v = aw + bw;
        MODE_SUB_S: v = aw - sw;
        MODE_SUB:   v = aw - bw;
        MODE_MUL_S: v = (WIDE_W'(s1_pm_r[i]) + HALF_W) >>> FRACTION_BITS;
        MODE_CROSS: v = (WIDE_W'(s1_pcp_r[i]) - WIDE_W'(s1_pcn_r[i]) + HALF_W)
                        >>> FRACTION_BITS;
        default:    v = '0;
      endcase
    end

    assign s2_res[i] = sat_word(v);
  end

  always_comb begin
    s2_side_nxt      = '0;
    s2_side_nxt.mode = s1_mode_r;
    s2_side_nxt.a    = s1_a_r;
    s2_side_nxt.b    = s1_b_r;
    s2_side_nxt.res  = s2_res;
    s2_side_nxt.eq   = (s1_a_r == s1_b_r);
  end

  always_ff @(posedge clk) begin
    s2_side_r <= s2_side_nxt;
    s2_sa_r   <= s1_sqa_r[0] + s1_sqa_r[1] + s1_sqa_r[2];
    s2_sb_r   <= s1_sqb_r[0] + s1_sqb_r[1] + s1_sqb_r[2];
  end

  // ---------------------------------------------------------------------------
  // stages 3-4: scale by 4^k until the radicand reaches 2^60
  // ---------------------------------------------------------------------------
  side_t           s3_side_nxt;
  side_t           s3_side_r;
  norm_t           s3_na_r;
  norm_t           s3_nb_r;
  logic [SQ_W-1:0] s3_sa_r;
  norm_t           s3_na_nxt;
  norm_t           s3_nb_nxt;

  always_comb begin
    s3_side_nxt    = s2_side_r;
    s3_side_nxt.za = (s2_sa_r == '0);
    s3_side_nxt.zb = (s2_sb_r == '0);
  end

  always_comb begin
    s3_na_nxt = norm_t'{s: s2_sa_r, k: '0};
    s3_nb_nxt = norm_t'{s: s2_sb_r, k: '0};
    s3_na_nxt = norm_step(s3_na_nxt, 16, NORM_TOP - 32);
    s3_nb_nxt = norm_step(s3_nb_nxt, 16, NORM_TOP - 32);
    s3_na_nxt = norm_step(s3_na_nxt, 8, NORM_TOP - 16);
    s3_nb_nxt = norm_step(s3_nb_nxt, 8, NORM_TOP - 16);
    s3_na_nxt = norm_step(s3_na_nxt, 4, NORM_TOP - 8);
    s3_nb_nxt = norm_step(s3_nb_nxt, 4, NORM_TOP - 8);
  end

  always_ff @(posedge clk) begin
    s3_side_r <= s3_side_nxt;
    s3_na_r   <= s3_na_nxt;
    s3_nb_r   <= s3_nb_nxt;
    s3_sa_r   <= s2_sa_r;
  end

  side_t           side_r [SIDE_N];
  side_t           s4_side_nxt;
  logic [SQ_W-1:0] s4_rad_a_r;
  logic [SQ_W-1:0] s4_rad_b_r;
  norm_t           s4_na_nxt;
  norm_t           s4_nb_nxt;

  // steps of 2 and 1 find the largest shift still below 2^60; the last one crosses it
  always_comb begin
    s4_na_nxt = norm_step(s3_na_r, 2, NORM_TOP - 4);
    s4_nb_nxt = norm_step(s3_nb_r, 2, NORM_TOP - 4);
    s4_na_nxt = norm_step(s4_na_nxt, 1, NORM_TOP - 2);
    s4_nb_nxt = norm_step(s4_nb_nxt, 1, NORM_TOP - 2);
    s4_na_nxt = norm_step(s4_na_nxt, 1, NORM_TOP);
    s4_nb_nxt = norm_step(s4_nb_nxt, 1, NORM_TOP);
  end

  always_comb begin
    s4_side_nxt    = s3_side_r;
    s4_side_nxt.ka = s4_na_nxt.k;
    s4_side_nxt.kb = s4_nb_nxt.k;
  end

  always_ff @(posedge clk) begin
    side_r[0]  <= s4_side_nxt;
    // magnitude takes the root of the raw sum, not the scaled one
    s4_rad_a_r <= (s3_side_r.mode == MODE_MAG) ? s3_sa_r : s4_na_nxt.s;
    s4_rad_b_r <= s4_nb_nxt.s;
  end

  // ---------------------------------------------------------------------------
  // square roots (first and second vector)
  // ---------------------------------------------------------------------------
  logic [ROOT_W-1:0] root_a;
  logic [ROOT_W-1:0] root_b;

  v3a_sqrt u_sqrt_a (
    .clk  (clk),
    .rad  (s4_rad_a_r),
    .root (root_a)
  );

  v3a_sqrt u_sqrt_b (
    .clk  (clk),
    .rad  (s4_rad_b_r),
    .root (root_b)
  );

  // sideband delay line; the magnitude is dropped in as the roots come out
  side_t side_mag;

  always_comb begin
    side_mag     = side_r[SQRT_LAT];
    side_mag.mag = (root_a > ROOT_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                      : root_a[WORD_W-1:0];
  end

  for (genvar j = 1; j < SIDE_N; j++) begin : g_side
    if (j == NUM_J) begin : g_mag
      always_ff @(posedge clk) begin
        side_r[j] <= side_mag;
      end
    end else begin : g_plain
      always_ff @(posedge clk) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // numerators, dividers, signed unit components and their products
  // ---------------------------------------------------------------------------
  logic [SQ_W-1:0]       num_a_r [3];
  logic [SQ_W-1:0]       num_b_r [3];
  logic [ROOT_W-1:0]     den_a_r;
  logic [ROOT_W-1:0]     den_b_r;
  logic [QB-1:0]         quo_a   [3];
  logic [QB-1:0]         quo_b   [3];
  logic signed [UW-1:0]  ua_r    [3];
  logic signed [PW-1:0]  prod_r  [3];

  always_ff @(posedge clk) begin
    den_a_r <= root_a;
    den_b_r <= root_b;
  end

  for (genvar i = 0; i < 3; i++) begin : g_unit
    word_t                abs_a;
    word_t                abs_b;
    logic signed [UW-1:0] ua;
    logic signed [UW-1:0] ub;

    assign abs_a = side_r[SQRT_LAT].a[i][WORD_W-1] ? -side_r[SQRT_LAT].a[i]
                                                   : side_r[SQRT_LAT].a[i];
    assign abs_b = side_r[SQRT_LAT].b[i][WORD_W-1] ? -side_r[SQRT_LAT].b[i]
                                                   : side_r[SQRT_LAT].b[i];

    // (|v| * 2^k * 2^F + R/2) / R rounds the component to nearest
    always_ff @(posedge clk) begin
      num_a_r[i] <= ((SQ_W'(abs_a) << side_r[SQRT_LAT].ka) << FRACTION_BITS)
                    + SQ_W'(root_a >> 1);
      num_b_r[i] <= ((SQ_W'(abs_b) << side_r[SQRT_LAT].kb) << FRACTION_BITS)
                    + SQ_W'(root_b >> 1);
    end

    v3a_div #(.QB(QB)) u_div_a (
      .clk (clk),
      .num (num_a_r[i]),
      .den (den_a_r),
      .quo (quo_a[i])
    );

    v3a_div #(.QB(QB)) u_div_b (
      .clk (clk),
      .num (num_b_r[i]),
      .den (den_b_r),
      .quo (quo_b[i])
    );

    assign ua = side_r[DIVQ_J].a[i][WORD_W-1] ? -$signed({1'b0, quo_a[i]})
                                              : $signed({1'b0, quo_a[i]});
    assign ub = side_r[DIVQ_J].b[i][WORD_W-1] ? -$signed({1'b0, quo_b[i]})
                                              : $signed({1'b0, quo_b[i]});

    always_ff @(posedge clk) begin
      ua_r[i]   <= ua;
      prod_r[i] <= PW'(ua) * PW'(ub);
    end
  end

  // ---------------------------------------------------------------------------
  // output stage
  // ---------------------------------------------------------------------------
  side_t                    fin;
  logic signed [WIDE_W-1:0] dot_sum;
  vec_t                     vec_nxt;
  word_t                    sc_nxt;
  logic                     eq_nxt;
  logic                     err_nxt;
  vec_t                     vec_r;
  word_t                    sc_r;
  logic                     eq_r;
  logic                     err_r;

  assign fin = side_r[PROD_J];

  always_comb begin
    dot_sum = '0;
    for (int i = 0; i < 3; i++) begin
      dot_sum = dot_sum + ((WIDE_W'(prod_r[i]) + HALF_W) >>> FRACTION_BITS);
    end
  end

  always_comb begin
    vec_nxt = '0;
    sc_nxt  = '0;
    eq_nxt  = 1'b0;
    err_nxt = 1'b0;
    case (fin.mode)
      MODE_NEG, MODE_ADD_S, MODE_ADD, MODE_SUB_S, MODE_SUB, MODE_MUL_S,
      MODE_CROSS: begin
        vec_nxt = fin.res;
      end
      MODE_DOT: begin
        if (fin.za || fin.zb) begin
          err_nxt = 1'b1;
        end else begin
          sc_nxt = sat_word(dot_sum);
        end
      end
      MODE_MAG: begin
        sc_nxt = fin.mag;
      end
      MODE_UNIT: begin
        if (fin.za) begin
          err_nxt = 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            vec_nxt[i] = sat_word(WIDE_W'(ua_r[i]));
          end
        end
      end
      MODE_EQ: begin
        eq_nxt = fin.eq;
      end
      default: begin
        vec_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    vec_r <= vec_nxt;
    sc_r  <= sc_nxt;
    eq_r  <= eq_nxt;
    err_r <= err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_x          = vec_r[0];
  assign out_y          = vec_r[1];
  assign out_z          = vec_r[2];
  assign out_scalar     = sc_r;
  assign out_equal_flag = eq_r;
  assign out_error_flag = err_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  a_fixed_latency : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted word did not come out after the pipeline latency");

  a_no_phantom : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching accepted word");

  a_error_zeroes : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_flag) |->
      (out_x == '0 && out_y == '0 && out_z == '0 && out_scalar == '0 && !out_equal_flag))
    else $error("error result carries nonzero fields");

  a_error_mode : assert property (@(posedge clk) disable iff (!rst_n)
    out_error_flag |-> $past(fin.mode == MODE_DOT || fin.mode == MODE_UNIT))
    else $error("error flag raised outside dot and unit modes");

endmodule

@@ dv/tb_vector3_fixed_point_alu.sv @@
// Self-checking testbench for vector3_fixed_point_alu (Q16.16 vector unit).
// A directed table, then random words, checked against typed-in results or a predictor.
// Depends on v3a_pkg and the RTL of the block.
module tb_vector3_fixed_point_alu;
  import v3a_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int LATENCY = FB + 42;
  localparam int N_RANDOM = 1100;

  // one result word
  typedef struct {
    logic [31:0] x, y, z, sc;
    logic        eq, err;
  } vres_t;

  // one input word
  typedef struct {
    logic [3:0]  mode;
    logic [31:0] a [3];
    logic [31:0] b [3];
    logic [31:0] s;
  } vop_t;

  // directed row: the expected result is typed in only when has_exp is set
  typedef struct {
    vop_t  op;
    bit    has_exp;
    vres_t exp;
  } row_t;

  logic        clk, rst_n, start, busy;
  logic [3:0]  in_mode;
  logic [31:0] in_first_x, in_first_y, in_first_z;
  logic [31:0] in_second_x, in_second_y, in_second_z, in_scalar_in;
  logic        out_valid, out_equal_flag, out_error_flag;
  logic [31:0] out_x, out_y, out_z, out_scalar;

  vres_t pending_results [$];
  int    n_fail = 0;
  int    idle_pct = 0;

  vector3_fixed_point_alu #(.FRACTION_BITS(FB)) i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor helpers. All arithmetic is done on 128-bit values so that
  // the exact intermediates (products, sums of squares shifted left) never wrap.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -128'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // round to nearest, ties toward +inf: floor((p + half) / 2^F)
  function automatic logic signed [127:0] rnd_q(input logic signed [127:0] p);
    return (p + (128'sd1 <<< (FB - 1))) >>> FB;
  endfunction

  // rounded integer square root: floor root, bumped when remainder > root
  function automatic logic [127:0] root_rnd(input logic [127:0] n);
    logic [127:0] r, b;
    r = 0;
    b = 128'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r = r + 1;
    return r;
  endfunction

  function automatic logic [127:0] sq_sum(input logic signed [127:0] v [3]);
    logic [127:0] t;
    t = 0;
    for (int i = 0; i < 3; i++) t = t + v[i] * v[i];
    return t;
  endfunction

  // unit vector; returns 0 for the zero vector
  function automatic bit unitize(input logic signed [127:0] v [3],
                                 output logic signed [127:0] u [3]);
    logic [127:0] s, r, n, q;
    int k;
    s = sq_sum(v);
    k = 0;
    for (int i = 0; i < 3; i++) u[i] = 0;
    if (s == 0) return 0;
    while (s < (128'd1 << 60)) begin
      s = s << 2;
      k++;
    end
    r = root_rnd(s);
    for (int i = 0; i < 3; i++) begin
      n = (v[i] < 0 ? -v[i] : v[i]);
      n = n << (k + FB);
      q = (n + (r >> 1)) / r;
      u[i] = v[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1;
  endfunction

  function automatic vres_t vec_alu_predict(input vop_t op);
    logic signed [127:0] a [3], b [3], r [3], ua [3], ub [3], s, sc;
    vres_t o;
    sc = 0;
    o.eq = 0;
    o.err = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(op.a[i]);
      b[i] = $signed(op.b[i]);
      r[i] = 0;
    end
    s = $signed(op.s);
    case (op.mode)
      MODE_NEG:   for (int i = 0; i < 3; i++) r[i] = -a[i];
      MODE_ADD_S: for (int i = 0; i < 3; i++) r[i] = a[i] + s;
      MODE_ADD:   for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
      MODE_SUB_S: for (int i = 0; i < 3; i++) r[i] = a[i] - s;
      MODE_SUB:   for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
      MODE_MUL_S: for (int i = 0; i < 3; i++) r[i] = rnd_q(a[i] * s);
      MODE_DOT: begin
        if (unitize(a, ua) && unitize(b, ub)) begin
          for (int i = 0; i < 3; i++) sc = sc + rnd_q(ua[i] * ub[i]);
        end else begin
          o.err = 1;
        end
      end
      MODE_CROSS: begin
        // exact difference, one rounding
        r[0] = rnd_q(a[1] * b[2] - a[2] * b[1]);
        r[1] = rnd_q(a[2] * b[0] - a[0] * b[2]);
        r[2] = rnd_q(a[0] * b[1] - a[1] * b[0]);
      end
      MODE_MAG: sc = $signed(root_rnd(sq_sum(a)));
      MODE_UNIT: begin
        if (unitize(a, ua)) begin
          r = ua;
        end else begin
          o.err = 1;
        end
      end
      MODE_EQ: o.eq = (op.a[0] == op.b[0]) && (op.a[1] == op.b[1]) && (op.a[2] == op.b[2]);
      default: ;  // unused codes give an all-zero word
    endcase
    o.x = clamp32(r[0]);
    o.y = clamp32(r[1]);
    o.z = clamp32(r[2]);
    o.sc = clamp32(sc);
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Random operand shapes: full range, small values near one, and corners.
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      3: return $urandom_range(0, 2);
      default: return 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh8_0000) <<< $urandom_range(0, 6);
    endcase
  endfunction

  function automatic vop_t rand_op();
    vop_t op;
    op.mode = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
    for (int i = 0; i < 3; i++) begin
      op.a[i] = rand_word();
      op.b[i] = rand_word();
    end
    op.s = rand_word();
    // equality mode mostly sees equal pairs, sometimes with one bit flipped
    if (op.mode == MODE_EQ && $urandom_range(0, 2) != 0) begin
      op.b = op.a;
      if ($urandom_range(0, 1)) op.b[$urandom_range(0, 2)][$urandom_range(0, 31)] ^= 1'b1;
    end
    // zero vectors for the error path
    if ((op.mode == MODE_DOT || op.mode == MODE_UNIT) && $urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1)) op.a = '{0, 0, 0};
      else op.b = '{0, 0, 0};
    end
    return op;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: one word per accepted handshake, idling at idle_pct percent.
  // ---------------------------------------------------------------------------
  task automatic send_word(input vop_t op, input bit has_exp, input vres_t exp);
    while ($urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_mode      <= op.mode;
    in_first_x   <= op.a[0];
    in_first_y   <= op.a[1];
    in_first_z   <= op.a[2];
    in_second_x  <= op.b[0];
    in_second_y  <= op.b[1];
    in_second_z  <= op.b[2];
    in_scalar_in <= op.s;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(has_exp ? exp : vec_alu_predict(op));
  endtask

  // Result checker: samples at the rising edge that ends the strobe cycle.
  always @(posedge clk) begin
    vres_t e;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word x=%h y=%h z=%h sc=%h eq=%b err=%b", $time,
                 out_x, out_y, out_z, out_scalar, out_equal_flag, out_error_flag);
        n_fail++;
      end else begin
        e = pending_results.pop_front();
        if (out_x !== e.x || out_y !== e.y || out_z !== e.z || out_scalar !== e.sc ||
            out_equal_flag !== e.eq || out_error_flag !== e.err) begin
          $display("%0t: mismatch exp x=%h y=%h z=%h sc=%h eq=%b err=%b", $time,
                   e.x, e.y, e.z, e.sc, e.eq, e.err);
          $display("%0t:          got x=%h y=%h z=%h sc=%h eq=%b err=%b", $time,
                   out_x, out_y, out_z, out_scalar, out_equal_flag, out_error_flag);
          n_fail++;
        end
      end
    end
  end

  // Directed table: extremes, every mode, zero vectors, negate of the minimum.
  localparam logic [31:0] MX = 32'h7FFF_FFFF;
  localparam logic [31:0] MN = 32'h8000_0000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] NON = 32'hFFFF_0000;

  function automatic row_t mk(input logic [3:0] m, input logic [31:0] ax, ay, az,
                              input logic [31:0] bx, by, bz, s, input bit he = 0,
                              input vres_t e = '{0, 0, 0, 0, 0, 0});
    row_t r;
    r.op.mode = m;
    r.op.a = '{ax, ay, az};
    r.op.b = '{bx, by, bz};
    r.op.s = s;
    r.has_exp = he;
    r.exp = e;
    return r;
  endfunction

  row_t dir_rows [$];

  initial begin
    vres_t z;
    z = '{0, 0, 0, 0, 0, 0};
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = '0;
    {in_first_x, in_first_y, in_first_z} = '0;
    {in_second_x, in_second_y, in_second_z, in_scalar_in} = '0;

    dir_rows.push_back(mk(MODE_NEG, MN, MX, 0, 0, 0, 0, 0, 1, '{MX, MN + 1, 0, 0, 0, 0}));
    dir_rows.push_back(mk(MODE_ADD_S, MX, MN, ONE, 0, 0, 0, MX, 1, '{MX, 32'hFFFF_FFFF,
                          MX, 0, 0, 0}));
    dir_rows.push_back(mk(MODE_ADD, MX, MN, ONE, MX, MN, NON, 0, 1, '{MX, MN, 0, 0, 0, 0}));
    dir_rows.push_back(mk(MODE_SUB_S, MN, MX, 0, 0, 0, 0, ONE, 1, '{MN, MX - ONE, NON,
                          0, 0, 0}));
    dir_rows.push_back(mk(MODE_SUB, MN, MX, ONE, MX, MN, ONE, 0, 1, '{MN, MX, 0, 0, 0, 0}));
    dir_rows.push_back(mk(MODE_MUL_S, MX, MN, ONE, 0, 0, 0, MN, 1, '{MN, MX, MN, 0, 0, 0}));
    dir_rows.push_back(mk(MODE_MUL_S, 32'h0000_8000, 32'hFFFF_8000, 3, 0, 0, 0, 32'h0000_8000));
    dir_rows.push_back(mk(MODE_DOT, ONE, 0, 0, 0, ONE, 0, 0, 1, z));
    dir_rows.push_back(mk(MODE_DOT, ONE, 0, 0, NON, 0, 0, 0, 1, '{0, 0, 0, NON, 0, 0}));
    dir_rows.push_back(mk(MODE_DOT, 0, 0, 0, ONE, ONE, ONE, 0, 1, '{0, 0, 0, 0, 0, 1}));
    dir_rows.push_back(mk(MODE_DOT, ONE, 2, 3, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}));
    dir_rows.push_back(mk(MODE_DOT, MN, MN, MN, MX, MX, MX, 0));
    dir_rows.push_back(mk(MODE_CROSS, ONE, 0, 0, 0, ONE, 0, 0, 1, '{0, 0, ONE, 0, 0, 0}));
    dir_rows.push_back(mk(MODE_CROSS, MN, MX, MN, MX, MN, MX, 0));
    dir_rows.push_back(mk(MODE_MAG, MN, MN, MN, 0, 0, 0, 0, 1, '{0, 0, 0, MX, 0, 0}));
    dir_rows.push_back(mk(MODE_MAG, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0, 1,
                          '{0, 0, 0, 32'h0005_0000, 0, 0}));
    dir_rows.push_back(mk(MODE_MAG, 0, 0, 0, 0, 0, 0, 0, 1, z));
    dir_rows.push_back(mk(MODE_UNIT, 0, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}));
    dir_rows.push_back(mk(MODE_UNIT, 0, 0, NON, 0, 0, 0, 0, 1, '{0, 0, NON, 0, 0, 0}));
    dir_rows.push_back(mk(MODE_UNIT, 1, MN, MX, 0, 0, 0, 0));
    dir_rows.push_back(mk(MODE_EQ, MN, MX, 1, MN, MX, 1, 0, 1, '{0, 0, 0, 0, 1, 0}));
    dir_rows.push_back(mk(MODE_EQ, MN, MX, 1, MN, MX, 0, 0, 1, z));
    dir_rows.push_back(mk(4'd11, MX, MX, MX, MX, MX, MX, MX, 1, z));
    dir_rows.push_back(mk(4'd15, MN, MN, MN, MN, MN, MN, MN, 1, z));
    dir_rows.push_back(mk(MODE_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          1, '{0, 0, 0, 0, 1, 0}));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, back to back
    foreach (dir_rows[i]) send_word(dir_rows[i].op, dir_rows[i].has_exp, dir_rows[i].exp);

    // hold off until the pipe has drained once
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // random words, sender idling per phase: 0%, 63%, 0%, 9% (receiver can't stall)
    for (int i = 0; i < N_RANDOM; i++) begin
      case (i * 4 / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 63;
        2: idle_pct = 0;
        default: idle_pct = 9;
      endcase
      send_word(rand_op(), 0, z);
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
